[hw/rtl/vmt_pkg.sv]
// Shared constants for the vertex matrix transform: widths, reset matrix, rounding.
`default_nettype none

package vmt_pkg;

   // Fixed-point format of vertex components and matrix elements
   localparam int FRAC_BITS = 16;
   localparam int DATA_W    = 32;

   // Matrix storage: two elements per configuration register
   localparam int NUM_REGS  = 8;
   localparam int NUM_ELEMS = 2 * NUM_REGS;
   localparam int NUM_COMP  = 4;
   localparam int CSR_W     = 2 * DATA_W;
   localparam int CSR_IDX_W = $clog2(NUM_REGS) + 1;

   // Accumulation widths: product, pair sum, four-term sum, rounded sum
   localparam int PROD_W = 2 * DATA_W;
   localparam int PAIR_W = PROD_W + 1;
   localparam int SUM_W  = PROD_W + 2;
   localparam int RND_W  = SUM_W + 1;

   // Half an LSB of the result; zero when there are no fraction bits
   localparam logic [RND_W-1:0] ROUND_TERM = RND_W'((68'd1 << FRAC_BITS) >> 1);

   localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   // Reset matrix is the identity
   localparam logic [CSR_W-1:0] MAT_RESET [NUM_REGS] = '{
      64'h0000_0000_0001_0000,
      64'h0000_0000_0000_0000,
      64'h0001_0000_0000_0000,
      64'h0000_0000_0000_0000,
      64'h0000_0000_0000_0000,
      64'h0000_0000_0001_0000,
      64'h0000_0000_0000_0000,
      64'h0001_0000_0000_0000
   };

endpackage

`default_nettype wire

[hw/rtl/vmt_req_if.sv]
// Request channel carrying one input vertex and its last flag.
`default_nettype none

interface vmt_req_if;
   logic                              valid;
   logic                              ready;
   logic signed [vmt_pkg::DATA_W-1:0] in_x;
   logic signed [vmt_pkg::DATA_W-1:0] in_y;
   logic signed [vmt_pkg::DATA_W-1:0] in_z;
   logic signed [vmt_pkg::DATA_W-1:0] in_w;
   logic                              in_last;

   modport source (output valid, in_x, in_y, in_z, in_w, in_last, input ready);
   modport sink   (input valid, in_x, in_y, in_z, in_w, in_last, output ready);
endinterface

`default_nettype wire

[hw/rtl/vmt_rsp_if.sv]
// Response channel carrying one transformed vertex and its last flag.
`default_nettype none

interface vmt_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [vmt_pkg::DATA_W-1:0] out_x;
   logic signed [vmt_pkg::DATA_W-1:0] out_y;
   logic signed [vmt_pkg::DATA_W-1:0] out_z;
   logic signed [vmt_pkg::DATA_W-1:0] out_w;
   logic                              out_last;

   modport source (output valid, out_x, out_y, out_z, out_w, out_last, input ready);
   modport sink   (input valid, out_x, out_y, out_z, out_w, out_last, output ready);
endinterface

`default_nettype wire

[hw/rtl/vertex_matrix_transform.sv]
// Top level: 4x4 fixed-point matrix times vertex, four-stage pipeline.
// Pipeline: four register stages (multiply, pair add, final add, round/saturate into the
//   output register) lie between the request port and the response port.
// Throughput: one request per cycle; every stage loads each cycle, and only a low rsp ready
//   holds the pipeline (a full pipeline then lowers req ready in the same cycle).
// Reset: synchronous, active high; empties the pipeline and loads the identity matrix.
`default_nettype none

module vertex_matrix_transform (
   input  wire logic                              clock,
   input  wire logic                              reset,
   vmt_req_if.sink                                req_bus,
   vmt_rsp_if.source                              rsp_bus,
   input  wire logic                              csr_write_en,
   input  wire logic [vmt_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [vmt_pkg::CSR_W-1:0]         csr_data
);

   localparam int NC = vmt_pkg::NUM_COMP;
   localparam int DW = vmt_pkg::DATA_W;

   // ---------------------------------------------------------------------------
   // Matrix registers. Writes beyond the last register are dropped.
   // ---------------------------------------------------------------------------
   logic [vmt_pkg::CSR_W-1:0] mat_ff [vmt_pkg::NUM_REGS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < vmt_pkg::NUM_REGS; r++) begin
            mat_ff[r] <= vmt_pkg::MAT_RESET[r];
         end
      end else if (csr_write_en) begin
         for (int r = 0; r < vmt_pkg::NUM_REGS; r++) begin
            if (csr_index == vmt_pkg::CSR_IDX_W'(r)) begin
               mat_ff[r] <= csr_data;
            end
         end
      end
   end

   // Element e sits in register e/2; even elements in the low half
   logic signed [DW-1:0] elem_w [vmt_pkg::NUM_ELEMS];

   for (genvar e = 0; e < vmt_pkg::NUM_ELEMS; e++) begin : g_elem
      assign elem_w[e] = $signed(mat_ff[e / 2][(e % 2) * DW +: DW]);
   end

   // ---------------------------------------------------------------------------
   // Pipeline flow control. A stage loads when it is empty or its content moves
   // on in the same cycle; valid bits travel with the data, so a stall holds only
   // the unbroken run of occupied stages at the output and bubbles are squeezed out.
   // ---------------------------------------------------------------------------
   logic s1_v_ff, s2_v_ff, s3_v_ff, out_v_ff;
   logic s1_en, s2_en, s3_en, out_en;

   assign out_en = !out_v_ff || rsp_bus.ready;
   assign s3_en  = !s3_v_ff || out_en;
   assign s2_en  = !s2_v_ff || s3_en;
   assign s1_en  = !s1_v_ff || s2_en;

   assign req_bus.ready = s1_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         s3_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         if (s1_en)  s1_v_ff  <= req_bus.valid;
         if (s2_en)  s2_v_ff  <= s1_v_ff;
         if (s3_en)  s3_v_ff  <= s2_v_ff;
         if (out_en) out_v_ff <= s3_v_ff;
      end
   end

   // ---------------------------------------------------------------------------
   // Stage 1: all sixteen products element[4k+c] * v[k], exact 64-bit.
   // ---------------------------------------------------------------------------
   logic signed [DW-1:0]                vec_w [NC];
   logic signed [vmt_pkg::PROD_W-1:0]   s1_prod_in [NC][NC];
   logic signed [vmt_pkg::PROD_W-1:0]   s1_prod_ff [NC][NC];
   logic                                s1_last_ff;

   assign vec_w[0] = req_bus.in_x;
   assign vec_w[1] = req_bus.in_y;
   assign vec_w[2] = req_bus.in_z;
   assign vec_w[3] = req_bus.in_w;

   always_comb begin
      for (int c = 0; c < NC; c++) begin
         for (int k = 0; k < NC; k++) begin
            s1_prod_in[c][k] = vmt_pkg::PROD_W'(elem_w[NC * k + c])
                             * vmt_pkg::PROD_W'(vec_w[k]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_en) begin
         s1_prod_ff <= s1_prod_in;
         s1_last_ff <= req_bus.in_last;
      end
   end

   // ---------------------------------------------------------------------------
   // Stage 2: add products in pairs (k=0,1 and k=2,3).
   // ---------------------------------------------------------------------------
   logic signed [vmt_pkg::PAIR_W-1:0] s2_pair_in [NC][2];
   logic signed [vmt_pkg::PAIR_W-1:0] s2_pair_ff [NC][2];
   logic                              s2_last_ff;

   always_comb begin
      for (int c = 0; c < NC; c++) begin
         for (int p = 0; p < 2; p++) begin
            s2_pair_in[c][p] = vmt_pkg::PAIR_W'(s1_prod_ff[c][2 * p])
                             + vmt_pkg::PAIR_W'(s1_prod_ff[c][2 * p + 1]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s2_en) begin
         s2_pair_ff <= s2_pair_in;
         s2_last_ff <= s1_last_ff;
      end
   end

   // ---------------------------------------------------------------------------
   // Stage 3: full four-term sum, no overflow possible at this width.
   // ---------------------------------------------------------------------------
   logic signed [vmt_pkg::SUM_W-1:0] s3_sum_in [NC];
   logic signed [vmt_pkg::SUM_W-1:0] s3_sum_ff [NC];
   logic                             s3_last_ff;

   always_comb begin
      for (int c = 0; c < NC; c++) begin
         s3_sum_in[c] = vmt_pkg::SUM_W'(s2_pair_ff[c][0]) + vmt_pkg::SUM_W'(s2_pair_ff[c][1]);
      end
   end

   always_ff @(posedge clock) begin
      if (s3_en) begin
         s3_sum_ff  <= s3_sum_in;
         s3_last_ff <= s2_last_ff;
      end
   end

   // ---------------------------------------------------------------------------
   // Stage 4: add half an LSB, drop the fraction bits, saturate to 32 bits.
   // The result fits when every bit from the result's sign bit upward agrees.
   // ---------------------------------------------------------------------------
   localparam int HI_LSB = vmt_pkg::FRAC_BITS + DW - 1;

   logic signed [vmt_pkg::RND_W-1:0]      rnd_w [NC];
   logic [vmt_pkg::RND_W-1-HI_LSB:0]      rnd_hi_w [NC];
   logic [DW-1:0]                         out_in [NC];
   logic [DW-1:0]                         out_ff [NC];
   logic                                  out_last_ff;

   always_comb begin
      for (int c = 0; c < NC; c++) begin
         rnd_w[c]    = vmt_pkg::RND_W'(s3_sum_ff[c]) + $signed(vmt_pkg::ROUND_TERM);
         rnd_hi_w[c] = rnd_w[c][vmt_pkg::RND_W-1:HI_LSB];
         if (&rnd_hi_w[c] || ~|rnd_hi_w[c]) begin
            out_in[c] = rnd_w[c][vmt_pkg::FRAC_BITS +: DW];
         end else if (rnd_w[c][vmt_pkg::RND_W-1]) begin
            out_in[c] = vmt_pkg::SAT_MIN;
         end else begin
            out_in[c] = vmt_pkg::SAT_MAX;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_en) begin
         out_ff      <= out_in;
         out_last_ff <= s3_last_ff;
      end
   end

   // Response port straight from the output register
   assign rsp_bus.valid    = out_v_ff;
   assign rsp_bus.out_x    = $signed(out_ff[0]);
   assign rsp_bus.out_y    = $signed(out_ff[1]);
   assign rsp_bus.out_z    = $signed(out_ff[2]);
   assign rsp_bus.out_w    = $signed(out_ff[3]);
   assign rsp_bus.out_last = out_last_ff;

endmodule

`default_nettype wire
